### rtl/swfr_pkg.sv
// Shared types and constants of the sliding-window sender with fast retransmit.
package swfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;
  localparam int SEQ_BITS_DEF     = 16;
  localparam int PORT_SEQ_W       = 16;
  localparam int DATA_W           = 64;
  localparam int CFG_W            = 4;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUP_TRIG    = 2'd1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 4'd4;
  localparam logic [CFG_W-1:0] DUP_TRIG_RST    = 4'd4;
  localparam logic [CFG_W-1:0] DUP_MAX         = 4'hF;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_IDLE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TX    = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  typedef struct packed {
    action_e                 action;
    logic [DATA_W-1:0]       payload;
    logic [PORT_SEQ_W-1:0]   ack_number;
    logic                    ack_ok;
    logic [PORT_SEQ_W-1:0]   timeout_seq;
  } item_t;

  // Up to three results of one item; a resend takes its transmit entry from the buffer.
  typedef struct packed {
    logic [1:0]                  cnt;
    kind_e [2:0]                 kind;
    logic [2:0][PORT_SEQ_W-1:0]  seq;
    logic                        acc;
    logic                        resend;
  } res_t;

endpackage

### rtl/swfr_mem.sv
// Retransmit buffer: payload and sequence store with a registered read port.
module swfr_mem #(
  parameter int BUFFER_DEPTH = swfr_pkg::BUFFER_DEPTH_DEF,
  parameter int SEQ_BITS     = swfr_pkg::SEQ_BITS_DEF,
  localparam int SW          = $clog2(BUFFER_DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [SW-1:0]                     wr_slot_i,
  input  logic [SEQ_BITS-1:0]               wr_seq_i,
  input  logic [swfr_pkg::DATA_W-1:0]       wr_data_i,
  input  logic                              rd_load_i,
  input  logic [SEQ_BITS-1:0]               rd_seq_i,
  output logic [swfr_pkg::PORT_SEQ_W-1:0]   rd_seq_o,
  output logic [swfr_pkg::DATA_W-1:0]       rd_data_o
);

  logic [swfr_pkg::DATA_W-1:0] mem_pl [BUFFER_DEPTH];
  logic [SEQ_BITS-1:0]         mem_seq [BUFFER_DEPTH];

  logic [SEQ_BITS-1:0]                      seq_q;
  logic [SW-1:0]                            rd_slot;
  logic [SEQ_BITS-1:0]                      rd_seq_q;
  logic [swfr_pkg::DATA_W-1:0]              rd_data_q;
  logic [SEQ_BITS+swfr_pkg::PORT_SEQ_W-1:0] seq_x;

  always_ff @(posedge clk_i) begin
    if (rd_load_i) begin
      seq_q <= rd_seq_i;
    end
  end

  // slot = seq mod depth
  if ((BUFFER_DEPTH & (BUFFER_DEPTH - 1)) == 0) begin : g_pow2
    logic [SEQ_BITS+SW-1:0] sx;
    assign sx      = (SEQ_BITS + SW)'(seq_q);
    assign rd_slot = sx[SW-1:0];
  end else begin : g_recip
    localparam int SH = SEQ_BITS + SW;
    localparam int PW = SH + SEQ_BITS + 1;
    localparam int RW = SEQ_BITS + SW + 1;
    localparam longint unsigned MULV =
      ((64'd1 << SH) + 64'(BUFFER_DEPTH) - 64'd1) / 64'(BUFFER_DEPTH);
    logic [PW-1:0]         prod_q;
    logic [SEQ_BITS:0]     quo;
    logic [RW-1:0]         rem;
    always_ff @(posedge clk_i) begin
      prod_q <= PW'(seq_q) * PW'(MULV);
    end
    assign quo     = prod_q[PW-1:SH];
    assign rem     = RW'(seq_q) - RW'(quo) * RW'(BUFFER_DEPTH);
    assign rd_slot = rem[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_pl[wr_slot_i]  <= wr_data_i;
      mem_seq[wr_slot_i] <= wr_seq_i;
    end
    rd_data_q <= mem_pl[rd_slot];
    rd_seq_q  <= mem_seq[rd_slot];
  end

  assign seq_x     = {{swfr_pkg::PORT_SEQ_W{1'b0}}, rd_seq_q};
  assign rd_seq_o  = seq_x[swfr_pkg::PORT_SEQ_W-1:0];
  assign rd_data_o = rd_data_q;

endmodule

### rtl/swfr_ctrl.sv
// Window state, duplicate-ACK tracker and per-item result decision.
module swfr_ctrl #(
  parameter int BUFFER_DEPTH = swfr_pkg::BUFFER_DEPTH_DEF,
  parameter int SEQ_BITS     = swfr_pkg::SEQ_BITS_DEF,
  localparam int SW          = $clog2(BUFFER_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swfr_pkg::item_t                item_i,
  input  logic                           fire_i,
  input  logic [swfr_pkg::CFG_W-1:0]     window_size_i,
  input  logic [swfr_pkg::CFG_W-1:0]     dup_trig_i,
  output swfr_pkg::res_t                 res_o,
  output logic                           wr_en_o,
  output logic [SW-1:0]                  wr_slot_o,
  output logic [SEQ_BITS-1:0]            wr_seq_o,
  output logic                           rd_load_o,
  output logic [SEQ_BITS-1:0]            rd_seq_o
);

  localparam int CW = (SEQ_BITS > 9) ? SEQ_BITS : 9;

  function automatic logic [swfr_pkg::PORT_SEQ_W-1:0] to_port(logic [SEQ_BITS-1:0] s);
    logic [SEQ_BITS+swfr_pkg::PORT_SEQ_W-1:0] x;
    x = {{swfr_pkg::PORT_SEQ_W{1'b0}}, s};
    return x[swfr_pkg::PORT_SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_BITS-1:0] from_port(logic [swfr_pkg::PORT_SEQ_W-1:0] p);
    logic [SEQ_BITS+swfr_pkg::PORT_SEQ_W-1:0] x;
    x = {{SEQ_BITS{1'b0}}, p};
    return x[SEQ_BITS-1:0];
  endfunction

  logic [SEQ_BITS-1:0]        base_q, base_d, next_q, next_d, last_q, last_d;
  logic                       full_q, full_d;
  logic [SW-1:0]              slot_q, slot_d;
  logic [swfr_pkg::CFG_W-1:0] dup_q, dup_d;

  logic [SEQ_BITS-1:0] outst, ack, tseq, ack_dist, t_dist, new_base, rs_seq, next_inc;
  logic [CW-1:0]       weff;
  logic                ack_new, do_resend, wr_en, rd_load;
  swfr_pkg::res_t      res_d;

  assign ack      = from_port(item_i.ack_number);
  assign tseq     = from_port(item_i.timeout_seq);
  assign outst    = next_q - base_q;
  assign ack_dist = ack - base_q;
  assign t_dist   = tseq - base_q;
  assign new_base = ack + 1'b1;
  assign next_inc = next_q + 1'b1;
  assign weff     = (CW'(window_size_i) > CW'(BUFFER_DEPTH)) ? CW'(BUFFER_DEPTH)
                                                             : CW'(window_size_i);
  assign ack_new  = item_i.ack_ok && (CW'(ack_dist) < CW'(window_size_i))
                    && (ack_dist < outst);
  assign rs_seq   = (item_i.action == swfr_pkg::ACT_TIMEOUT) ? tseq : base_q;

  always_comb begin
    res_d     = '0;
    res_d.cnt = 2'd1;
    base_d    = base_q;
    next_d    = next_q;
    full_d    = full_q;
    slot_d    = slot_q;
    last_d    = last_q;
    dup_d     = dup_q;
    wr_en     = 1'b0;
    do_resend = 1'b0;
    case (item_i.action)
      swfr_pkg::ACT_SEND: begin
        if (!(full_q || CW'(outst) >= weff)) begin
          wr_en     = 1'b1;
          res_d.acc = 1'b1;
          if (base_q == next_q) begin
            res_d.cnt     = 2'd2;
            res_d.kind[0] = swfr_pkg::KIND_START;
            res_d.seq[0]  = to_port(base_q);
            res_d.kind[1] = swfr_pkg::KIND_TX;
            res_d.seq[1]  = to_port(next_q);
          end else begin
            res_d.kind[0] = swfr_pkg::KIND_TX;
            res_d.seq[0]  = to_port(next_q);
          end
          next_d = next_inc;
          if (next_inc == '0 || slot_q == SW'(BUFFER_DEPTH - 1)) begin
            slot_d = '0;
          end else begin
            slot_d = slot_q + 1'b1;
          end
          full_d = (CW'(SEQ_BITS'(next_inc - base_q)) == weff);
        end
      end
      swfr_pkg::ACT_ACK: begin
        if (ack_new) begin
          base_d        = new_base;
          full_d        = 1'b0;
          res_d.kind[0] = swfr_pkg::KIND_STOP;
          res_d.seq[0]  = to_port(base_q);
          if (new_base != next_q) begin
            res_d.cnt     = 2'd2;
            res_d.kind[1] = swfr_pkg::KIND_START;
            res_d.seq[1]  = to_port(new_base);
          end
        end else if (ack == last_q) begin
          dup_d = (dup_q == swfr_pkg::DUP_MAX) ? dup_q : dup_q + 1'b1;
          do_resend = (dup_d == dup_trig_i) && (outst != '0);
        end else begin
          last_d = ack;
          dup_d  = 4'd1;
        end
      end
      swfr_pkg::ACT_TIMEOUT: begin
        do_resend = (t_dist < outst);
      end
      default: begin
      end
    endcase
    if (do_resend) begin
      res_d.cnt     = 2'd3;
      res_d.kind[0] = swfr_pkg::KIND_STOP;
      res_d.seq[0]  = to_port(rs_seq);
      res_d.kind[1] = swfr_pkg::KIND_START;
      res_d.seq[1]  = to_port(rs_seq);
      res_d.kind[2] = swfr_pkg::KIND_TX;
      res_d.resend  = 1'b1;
    end
    rd_load = do_resend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      next_q <= '0;
      full_q <= 1'b0;
      slot_q <= '0;
      last_q <= '1;
      dup_q  <= '0;
    end else if (fire_i) begin
      base_q <= base_d;
      next_q <= next_d;
      full_q <= full_d;
      slot_q <= slot_d;
      last_q <= last_d;
      dup_q  <= dup_d;
    end
  end

  assign res_o     = res_d;
  assign wr_en_o   = fire_i & wr_en;
  assign wr_slot_o = slot_q;
  assign wr_seq_o  = next_q;
  assign rd_load_o = fire_i & rd_load;
  assign rd_seq_o  = rs_seq;

  a_full_has_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> outst != '0) else $error("window full with nothing outstanding");

  a_outstanding_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(outst) <= CW'(BUFFER_DEPTH)) else $error("outstanding exceeds buffer depth");

endmodule

### rtl/swfr_out.sv
// Result register: holds up to three results of one item and hands them out in order.
module swfr_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  swfr_pkg::res_t                    res_i,
  input  logic [swfr_pkg::DATA_W-1:0]       payload_i,
  input  logic [swfr_pkg::PORT_SEQ_W-1:0]   rd_seq_i,
  input  logic [swfr_pkg::DATA_W-1:0]       rd_data_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [swfr_pkg::PORT_SEQ_W-1:0]   seq_o,
  output logic [swfr_pkg::DATA_W-1:0]       data_out_o,
  output logic                              accepted_o,
  output logic                              last_o
);

  logic                        valid_q;
  logic [1:0]                  idx_q;
  swfr_pkg::res_t              r_q;
  logic [swfr_pkg::DATA_W-1:0] pl_q;
  logic                        tx_mem;
  swfr_pkg::kind_e             kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r_q  <= res_i;
      pl_q <= payload_i;
    end
  end

  assign tx_mem      = r_q.resend && (idx_q == 2'd2);
  assign kind        = r_q.kind[idx_q];
  assign kind_o      = kind;
  assign seq_o       = tx_mem ? rd_seq_i : r_q.seq[idx_q];
  assign data_out_o  = (kind != swfr_pkg::KIND_TX) ? '0 : (tx_mem ? rd_data_i : pl_q);
  assign accepted_o  = r_q.acc;
  assign last_o      = (idx_q == r_q.cnt - 2'd1);
  assign out_valid_o = valid_q;
  assign free_o      = !valid_q || (out_ready_i && last_o);

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q < r_q.cnt) else $error("result index past count");

  a_resend_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && r_q.resend |-> r_q.cnt == 2'd3 && !r_q.acc)
    else $error("resend without three results");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_ready_i && last_o && !load_i |=> !valid_q)
    else $error("result register not emptied after last transfer");

endmodule

### rtl/sliding_window_sender_fast_retx_unit.sv
// Top level of the sliding-window sender with fast retransmit.
//
// Channels: in_* carries one event (send, ACK, timer expiry); out_* carries
// the result items, one to three per event, the final one marked by last_o.
// cfg_* writes window_size (index 0) and dup_ack_trigger (index 1); it is
// always ready and must only be used while the block is idle.
// An event waits in the input register until the result register is free; it
// then moves into the result register, where its first result is visible and
// can transfer.
// A resend reads the retransmit buffer through a sequence register (plus a
// product register when the depth is not a power of two) and a registered
// read port; its transmit result is the third one, so it never waits on that read.
// Throughput: one result item per cycle while out_ready_i is high; an event
// holds the result register until all its results (1 to 3) are taken, while the
// input register already holds the next event.
// Reset: window base and next sequence zero, window not full, duplicate
// tracker at all ones with count zero, registers at 4. The buffer is not
// cleared; only outstanding entries, which were written, are read.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready_o drops until the current results are taken.
module sliding_window_sender_fast_retx_unit #(
  parameter int BUFFER_DEPTH = swfr_pkg::BUFFER_DEPTH_DEF,
  parameter int SEQ_BITS     = swfr_pkg::SEQ_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [swfr_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [swfr_pkg::DATA_W-1:0]       payload_i,
  input  logic [swfr_pkg::PORT_SEQ_W-1:0]   ack_number_i,
  input  logic                              ack_checksum_ok_i,
  input  logic [swfr_pkg::PORT_SEQ_W-1:0]   timeout_seq_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [swfr_pkg::PORT_SEQ_W-1:0]   seq_o,
  output logic [swfr_pkg::DATA_W-1:0]       data_out_o,
  output logic                              accepted_o,
  output logic                              last_o
);

  localparam int SW = $clog2(BUFFER_DEPTH);

  logic [swfr_pkg::CFG_W-1:0] window_size_q, dup_trig_q;
  logic                       in_valid_q;
  swfr_pkg::item_t            item_q;
  logic                       out_free, fire;

  swfr_pkg::res_t                     res;
  logic                               wr_en, rd_load;
  logic [SW-1:0]                      wr_slot;
  logic [SEQ_BITS-1:0]                wr_seq, rd_seq;
  logic [swfr_pkg::PORT_SEQ_W-1:0]    mem_seq;
  logic [swfr_pkg::DATA_W-1:0]        mem_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swfr_pkg::WINDOW_SIZE_RST;
      dup_trig_q    <= swfr_pkg::DUP_TRIG_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == swfr_pkg::REG_WINDOW_SIZE) begin
        window_size_q <= cfg_data_i;
      end else if (cfg_index_i == swfr_pkg::REG_DUP_TRIG) begin
        dup_trig_q <= cfg_data_i;
      end
    end
  end

  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action      <= swfr_pkg::action_e'(action_i);
      item_q.payload     <= payload_i;
      item_q.ack_number  <= ack_number_i;
      item_q.ack_ok      <= ack_checksum_ok_i;
      item_q.timeout_seq <= timeout_seq_i;
    end
  end

  swfr_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SEQ_BITS     (SEQ_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_q),
    .fire_i        (fire),
    .window_size_i (window_size_q),
    .dup_trig_i    (dup_trig_q),
    .res_o         (res),
    .wr_en_o       (wr_en),
    .wr_slot_o     (wr_slot),
    .wr_seq_o      (wr_seq),
    .rd_load_o     (rd_load),
    .rd_seq_o      (rd_seq)
  );

  swfr_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SEQ_BITS     (SEQ_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_slot_i (wr_slot),
    .wr_seq_i  (wr_seq),
    .wr_data_i (item_q.payload),
    .rd_load_i (rd_load),
    .rd_seq_i  (rd_seq),
    .rd_seq_o  (mem_seq),
    .rd_data_o (mem_data)
  );

  swfr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res),
    .payload_i   (item_q.payload),
    .rd_seq_i    (mem_seq),
    .rd_data_i   (mem_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .seq_o       (seq_o),
    .data_out_o  (data_out_o),
    .accepted_o  (accepted_o),
    .last_o      (last_o)
  );

endmodule
